FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, empty when built for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, disabled while the active-low reset is asserted
`define ASSERT_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CHECK(lbl, clk, rstn, !(cond), msg)

`else

`define ASSERT_CHECK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: sv/psspan_pkg.sv
// ---------------------------------------------------------------------------
// psspan_pkg
// shared constants, types and the reflect intensity function of the
// polygon scanline span block
// ---------------------------------------------------------------------------
`default_nettype none

package psspan_pkg;

    // parameter defaults
    localparam int MAX_CORNERS_DEF = 16;
    localparam int COORD_BITS_DEF  = 13;

    // fixed field widths
    localparam int SCREEN_W   = 12;
    localparam int INTENS_W   = 8;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = OUT_DATA_W - (4 * SCREEN_W + 1 + INTENS_W);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT = 2'd2;

    localparam logic [SCREEN_W-1:0] RST_MAX_X = 12'd639;
    localparam logic [SCREEN_W-1:0] RST_MAX_Y = 12'd479;

    // request kinds carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // reflect-mode dimming, wraps like the 8-bit counter it mirrors
    function automatic logic [INTENS_W-1:0] reduce_intensity(
        input logic [INTENS_W-1:0] v,
        input logic                reflect
    );
        logic [INTENS_W-1:0] r;
        r = v;
        if (reflect && (v >= 8'd2)) begin
            case (v)
                8'd2:    r = 8'd255;
                8'd3:    r = 8'd2;
                8'd4:    r = 8'd1;
                8'd5:    r = 8'd3;
                default: r = v - 8'd3;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/polygon_scanline_span.sv
// ---------------------------------------------------------------------------
// polygon_scanline_span
// scan converter for one polygon facet: corner loads, row range, row spans
// ---------------------------------------------------------------------------
//
//  channel    dir  handshake                       contents
//  s_axis     in   i_s_axis_tvalid/o_s_axis_tready tuser req_type, tlast last_vertex,
//                                                  tdata corner and query fields
//  m_axis     out  o_m_axis_tvalid/i_m_axis_tready tdata row range, span, intensity
//  cfg        in   i_cfg_we                        screen_max_x, screen_max_y, reflect
//
//  a load stores the corner and updates the row range, then the result register;
//  a query reads the closing edge, then per edge tests the row and, when it crosses
//  it, multiplies, takes signs and divides (QW = COORD_BITS + 2 quotient bits) on the
//  one-bit-per-cycle shared divider and accumulates; a fetch between edges, then finish
//  input is taken only in idle; the result register lets the next item in
//  while a result waits; reset is synchronous, the corner store is not cleared
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module polygon_scanline_span import psspan_pkg::*; #(
    parameter int MAX_CORNERS = MAX_CORNERS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // request stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: vert_x, vert_y, scan_row, facet_intensity, zero pad
    input  wire logic [((2*COORD_BITS+SCREEN_W+INTENS_W+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: req_type
    input  wire logic                  i_s_axis_tuser,
    // tlast: last_vertex
    input  wire logic                  i_s_axis_tlast,
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: row_first, row_last, span_left, span_right, span_draw,
    //        intensity_out, zero pad
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int C    = COORD_BITS;
    localparam int IW   = $clog2(MAX_CORNERS);
    localparam int CW   = $clog2(MAX_CORNERS + 1);
    localparam int RW   = ((C > 13) ? C : 13) + 1;
    localparam int XW   = RW + 1;
    localparam int DXW  = C + 1;
    localparam int PW   = DXW + RW;
    localparam int NW   = PW + 2;
    localparam int DW   = DXW + 1;
    localparam int QW   = C + 2;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDOLD = 4'd1;
    localparam logic [3:0] ST_RDNEW = 4'd2;
    localparam logic [3:0] ST_FETCH = 4'd3;
    localparam logic [3:0] ST_EDGE  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_SIGN  = 4'd6;
    localparam logic [3:0] ST_DST   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_ACC   = 4'd9;
    localparam logic [3:0] ST_NEXT  = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    // configuration registers
    logic [SCREEN_W-1:0] r_max_x;
    logic [SCREEN_W-1:0] r_max_y;
    logic                r_reflect;

    // control state
    logic [3:0]          r_state;
    logic [CW-1:0]       r_count;
    logic                r_restart;
    logic signed [C-1:0] r_lo;
    logic signed [C-1:0] r_hi;
    logic                r_out_valid;

    // query datapath
    logic [SCREEN_W-1:0]   r_row;
    logic [INTENS_W-1:0]   r_raw;
    logic                  r_isq;
    logic [IW-1:0]         r_i;
    logic signed [C-1:0]   r_xo;
    logic signed [C-1:0]   r_yo;
    logic signed [DXW-1:0] r_dx;
    logic signed [RW-1:0]  r_dr;
    logic signed [DXW-1:0] r_den;
    logic signed [PW-1:0]  r_num;
    logic [NW-1:0]         r_dnum;
    logic [DW-1:0]         r_dden;
    logic                  r_neg;
    logic signed [XW-1:0]  r_mnx;
    logic signed [XW-1:0]  r_mxx;

    // corner store
    logic [C-1:0]        mem_x [MAX_CORNERS];
    logic [C-1:0]        mem_y [MAX_CORNERS];
    logic signed [C-1:0] r_rd_x;
    logic signed [C-1:0] r_rd_y;
    logic [IW-1:0]       w_rd_addr;

    // result register
    logic [SCREEN_W-1:0] r_o_first;
    logic [SCREEN_W-1:0] r_o_last;
    logic [SCREEN_W-1:0] r_o_left;
    logic [SCREEN_W-1:0] r_o_right;
    logic                r_o_draw;
    logic [INTENS_W-1:0] r_o_inten;

    // input fields
    logic signed [C-1:0] w_in_x;
    logic signed [C-1:0] w_in_y;
    logic [SCREEN_W-1:0] w_in_row;
    logic [INTENS_W-1:0] w_in_int;
    logic                w_accept;
    logic                w_store;
    logic [IW-1:0]       w_widx;

    // divider hookup
    t_div_sts      div_sts;
    logic [QW-1:0] div_quot;

    // edge, sign, accumulate and finish terms
    logic signed [RW-1:0]  w_yo;
    logic signed [RW-1:0]  w_yv;
    logic signed [RW-1:0]  w_row_s;
    logic                  w_touch;
    logic [PW-1:0]         w_an;
    logic [DXW-1:0]        w_ad;
    logic signed [XW-1:0]  w_q;
    logic signed [XW-1:0]  w_x;
    logic signed [XW-1:0]  w_maxx_s;
    logic signed [XW-1:0]  w_l;
    logic signed [XW-1:0]  w_r;
    logic                  w_span;
    logic signed [RW-1:0]  w_lo;
    logic signed [RW-1:0]  w_hi;
    logic signed [RW-1:0]  w_my;
    logic signed [RW-1:0]  w_loc;
    logic signed [RW-1:0]  w_hic;
    logic                  w_empty;
    logic                  w_out_free;
    logic                  w_last_edge;

    // unpack the request item
    assign w_in_x   = i_s_axis_tdata[C-1:0];
    assign w_in_y   = i_s_axis_tdata[2*C-1:C];
    assign w_in_row = i_s_axis_tdata[2*C+SCREEN_W-1:2*C];
    assign w_in_int = i_s_axis_tdata[2*C+SCREEN_W+INTENS_W-1:2*C+SCREEN_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // load slot: a pending restart writes slot zero, a full store drops it
    assign w_store = r_restart || (r_count < CW'(MAX_CORNERS));
    assign w_widx  = r_restart ? '0 : IW'(r_count);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x   <= RST_MAX_X;
            r_max_y   <= RST_MAX_Y;
            r_reflect <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_X:   r_max_x   <= i_cfg_wdata[SCREEN_W-1:0];
                CFG_MAX_Y:   r_max_y   <= i_cfg_wdata[SCREEN_W-1:0];
                CFG_REFLECT: r_reflect <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // corner store, one write port and one registered read port
    assign w_rd_addr = (r_state == ST_RDOLD) ? IW'(r_count - CW'(1)) : r_i;

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_s_axis_tuser == REQ_LOAD) && w_store) begin
            mem_x[w_widx] <= w_in_x;
            mem_y[w_widx] <= w_in_y;
        end
        r_rd_x <= mem_x[w_rd_addr];
        r_rd_y <= mem_y[w_rd_addr];
    end

    // edge touch test against the queried row
    assign w_yo    = RW'(r_yo);
    assign w_yv    = RW'(r_rd_y);
    assign w_row_s = RW'($signed({1'b0, r_row}));
    assign w_touch = ((w_yo >= w_row_s) || (w_yv >= w_row_s)) &&
                     ((w_yo <= w_row_s) || (w_yv <= w_row_s)) && (w_yo != w_yv);

    // magnitudes for the divider
    assign w_an = r_num[PW-1] ? PW'(-r_num) : PW'(r_num);
    assign w_ad = r_den[DXW-1] ? DXW'(-r_den) : DXW'(r_den);

    // crossing column
    assign w_q = $signed(XW'(div_quot));
    assign w_x = XW'(r_xo) + (r_neg ? -w_q : w_q);

    // span clip
    assign w_maxx_s = $signed(XW'(r_max_x));
    assign w_l      = (r_mnx < 0) ? '0 : r_mnx;
    assign w_r      = (r_mxx > w_maxx_s) ? w_maxx_s : r_mxx;
    assign w_span   = (w_l <= w_r);

    // row range clip
    assign w_lo    = RW'(r_lo);
    assign w_hi    = RW'(r_hi);
    assign w_my    = $signed(RW'(r_max_y));
    assign w_loc   = (w_lo < 0) ? '0 : w_lo;
    assign w_hic   = (w_hi > w_my) ? w_my : w_hi;
    assign w_empty = (r_count == '0) || (w_loc > w_hic);

    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_last_edge = ((CW'(r_i) + CW'(1)) == r_count);

    // sequencer and facet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_restart   <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result valid: set by a finishing item, cleared when taken
            if ((r_state == ST_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_s_axis_tuser == REQ_LOAD) begin
                            r_restart <= i_s_axis_tlast;
                            if (w_store) begin
                                r_count <= CW'(w_widx) + CW'(1);
                                if (w_widx == '0) begin
                                    r_lo <= w_in_y;
                                    r_hi <= w_in_y;
                                end else begin
                                    if (w_in_y < r_lo) r_lo <= w_in_y;
                                    if (w_in_y > r_hi) r_hi <= w_in_y;
                                end
                            end
                            r_state <= ST_FIN;
                        end else if ((w_in_row > r_max_y) || (r_count == '0)) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_RDOLD;
                        end
                    end
                end
                ST_RDOLD: r_state <= ST_RDNEW;
                ST_RDNEW: r_state <= ST_EDGE;
                ST_FETCH: r_state <= ST_EDGE;
                ST_EDGE:  r_state <= w_touch ? ST_MUL : ST_NEXT;
                ST_MUL:   r_state <= ST_SIGN;
                ST_SIGN:  r_state <= ST_DST;
                ST_DST:   r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_sts.done) r_state <= ST_ACC;
                end
                ST_ACC:   r_state <= ST_NEXT;
                ST_NEXT:  r_state <= w_last_edge ? ST_FIN : ST_FETCH;
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    // query datapath and result register
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_row <= w_in_row;
                r_raw <= w_in_int;
                r_isq <= (i_s_axis_tuser == REQ_QUERY);
                r_mnx <= XW'(w_maxx_s + XW'(1));
                r_mxx <= -XW'(1);
                r_i   <= '0;
            end
            ST_RDNEW: begin
                r_xo <= r_rd_x;
                r_yo <= r_rd_y;
            end
            ST_EDGE: begin
                r_dx  <= DXW'(r_rd_x) - DXW'(r_xo);
                r_dr  <= w_row_s - w_yo;
                r_den <= DXW'(r_rd_y) - DXW'(r_yo);
            end
            ST_MUL: begin
                r_num <= PW'(r_dx) * PW'(r_dr);
            end
            ST_SIGN: begin
                r_dnum <= NW'({w_an, 1'b0}) + NW'(w_ad);
                r_dden <= {w_ad, 1'b0};
                r_neg  <= r_num[PW-1] ^ r_den[DXW-1];
            end
            ST_ACC: begin
                if (w_x < r_mnx) r_mnx <= w_x;
                if (w_x > r_mxx) r_mxx <= w_x;
            end
            ST_NEXT: begin
                r_xo <= r_rd_x;
                r_yo <= r_rd_y;
                r_i  <= r_i + IW'(1);
            end
            ST_FIN: begin
                if (w_out_free) begin
                    r_o_first <= w_empty ? SCREEN_W'(1) : w_loc[SCREEN_W-1:0];
                    r_o_last  <= w_empty ? '0 : w_hic[SCREEN_W-1:0];
                    if (r_isq && w_span) begin
                        r_o_left  <= w_l[SCREEN_W-1:0];
                        r_o_right <= w_r[SCREEN_W-1:0];
                        r_o_draw  <= (r_raw != '0);
                    end else begin
                        r_o_left  <= '0;
                        r_o_right <= '0;
                        r_o_draw  <= 1'b0;
                    end
                    r_o_inten <= r_isq ? reduce_intensity(r_raw, r_reflect) : '0;
                end
            end
            default: ;
        endcase
    end

    // shared divider for all edge crossings
    psspan_div #(
        .NW(NW),
        .DW(DW),
        .QW(QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DST),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // result item
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_inten, r_o_draw, r_o_right,
                              r_o_left, r_o_last, r_o_first};

    `ASSERT_CHECK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_CORNERS), "corner count beyond store depth")
    `ASSERT_CHECK(a_edge_index, i_clk, i_rst_n, (r_state == ST_EDGE) |-> (CW'(r_i) < r_count), "edge walk past stored corners")
    `ASSERT_CHECK(a_fin_hold, i_clk, i_rst_n, ((r_state == ST_FIN) && r_out_valid && !i_m_axis_tready) |=> (r_state == ST_FIN), "result overwrote a waiting item")

endmodule

`default_nettype wire

FILE: sv/psspan_div.sv
// ---------------------------------------------------------------------------
// psspan_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psspan_div import psspan_pkg::*; #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output t_div_sts           o_sts,
    output logic      [QW-1:0] o_quot
);

    localparam int CNTW = $clog2(QW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [QW-1:0]   r_shq;

    logic [DW:0]     w_trial;
    logic            w_fit;

    // trial subtract of the shifted remainder
    assign w_trial = {r_rem, r_shq[QW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // control: busy for QW steps, done pulses after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: high numerator bits seed the remainder, quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num >> QW);
            r_shq <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? DW'(w_trial - {1'b0, r_den}) : DW'(w_trial);
            r_shq <= {r_shq[QW-2:0], w_fit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_shq;

    `ASSERT_NEVER(a_div_restart, i_clk, i_rst_n, i_start && r_busy, "divider restarted while busy")
    `ASSERT_CHECK(a_div_done, i_clk, i_rst_n, r_done |-> $past(r_busy), "done without a run")
    `ASSERT_CHECK(a_div_idle_done, i_clk, i_rst_n, r_done |-> !r_busy, "done while still busy")

endmodule

`default_nettype wire

FILE: sim/polygon_scanline_span_tb.sv
// ----------------------------------------------------------------------------
// polygon_scanline_span_tb
// Self-checking bench for the facet scan converter. It loads corner rings,
// queries row spans and checks every result against a span predictor kept
// beside the block. Both streams idle and stall at random. Screen size and
// reflect mode are rewritten between phases, with the extreme values included.
// ----------------------------------------------------------------------------
`default_nettype none

import psspan_pkg::*;

// one result item as the block packs it, fields in result order
typedef struct packed {
    logic [6:0]          pad;
    logic [INTENS_W-1:0] intensity;
    logic                span_draw;
    logic [SCREEN_W-1:0] span_right;
    logic [SCREEN_W-1:0] span_left;
    logic [SCREEN_W-1:0] row_last;
    logic [SCREEN_W-1:0] row_first;
} span_result_t;

// facet span predictor and store of expected results
class span_scoreboard;
    span_result_t        expected_q[$];
    int                  errors;
    int                  checked;
    logic [SCREEN_W-1:0] max_x;
    logic [SCREEN_W-1:0] max_y;
    logic                reflect;
    longint              cx[MAX_CORNERS_DEF];
    longint              cy[MAX_CORNERS_DEF];
    int                  count;
    bit                  restart;
    longint              low_row;
    longint              high_row;

    function void power_on();
        expected_q.delete();
        errors   = 0;
        checked  = 0;
        max_x    = RST_MAX_X;
        max_y    = RST_MAX_Y;
        reflect  = 1'b0;
        count    = 0;
        restart  = 1'b0;
        low_row  = 0;
        high_row = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MAX_X:   max_x = val;
            CFG_MAX_Y:   max_y = val;
            CFG_REFLECT: reflect = val[0];
            default: ;
        endcase
    endfunction

    // reflect dimming, wrapping at 8 bits
    function logic [INTENS_W-1:0] dim(logic [INTENS_W-1:0] v);
        logic [INTENS_W-1:0] w;
        w = v;
        if (reflect && v >= 8'd2) begin
            w = w - 8'd1;
            if (w != 8'd2) begin
                w = w - 8'd1;
                if (w != 8'd3)
                    w = w - 8'd1;
            end
        end
        return w;
    endfunction

    // quotient rounded half away from zero
    function longint div_away(longint num, longint den);
        longint an, ad, q;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q  = (2 * an + ad) / (2 * ad);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function void note_request(logic kind, logic [COORD_BITS_DEF-1:0] vx,
                               logic [COORD_BITS_DEF-1:0] vy, logic last,
                               logic [SCREEN_W-1:0] row, logic [INTENS_W-1:0] inten);
        span_result_t r;
        longint       rowv, limx, limy, mnx, mxx, yo, yv, x, lo, hi;
        int           i, prev;
        r    = '0;
        limx = longint'(max_x);
        limy = longint'(max_y);
        if (kind == REQ_LOAD) begin
            if (restart) begin
                count   = 0;
                restart = 1'b0;
            end
            if (count < MAX_CORNERS_DEF) begin
                cx[count] = longint'($signed(vx));
                cy[count] = longint'($signed(vy));
                count++;
            end
            if (last)
                restart = 1'b1;
            low_row  = cy[0];
            high_row = cy[0];
            for (i = 1; i < count; i++) begin
                if (cy[i] < low_row) low_row = cy[i];
                if (cy[i] > high_row) high_row = cy[i];
            end
        end else begin
            rowv        = longint'(row);
            r.intensity = dim(inten);
            mnx         = limx + 1;
            mxx         = -1;
            // walk the ring starting with the closing edge
            if (rowv <= limy && count > 0) begin
                prev = count - 1;
                for (i = 0; i < count; i++) begin
                    yo = cy[prev];
                    yv = cy[i];
                    if ((yo >= rowv || yv >= rowv) && (yo <= rowv || yv <= rowv) && yo != yv) begin
                        x = cx[prev] + div_away((cx[i] - cx[prev]) * (rowv - yo), yv - yo);
                        if (x < mnx) mnx = x;
                        if (x > mxx) mxx = x;
                    end
                    prev = i;
                end
            end
            if (mnx < 0) mnx = 0;
            if (mxx > limx) mxx = limx;
            if (mnx <= mxx) begin
                r.span_left  = mnx[SCREEN_W-1:0];
                r.span_right = mxx[SCREEN_W-1:0];
                r.span_draw  = (inten != 0);
            end
        end
        // row range of the stored facet, clipped to the screen
        lo = (low_row < 0) ? 0 : low_row;
        hi = (high_row > limy) ? limy : high_row;
        if (count == 0 || lo > hi) begin
            r.row_first = 12'd1;
            r.row_last  = 12'd0;
        end else begin
            r.row_first = lo[SCREEN_W-1:0];
            r.row_last  = hi[SCREEN_W-1:0];
        end
        expected_q.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s", msg);
    endtask

    task compare(string name, int got, int want);
        if (got != want)
            report($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
        span_result_t got, want;
        got = d;
        if (expected_q.size() == 0) begin
            report($sformatf("result %0h arrived with no request pending", d));
        end else begin
            want = expected_q.pop_front();
            compare("row_first", got.row_first, want.row_first);
            compare("row_last", got.row_last, want.row_last);
            compare("span_left", got.span_left, want.span_left);
            compare("span_right", got.span_right, want.span_right);
            compare("span_draw", got.span_draw, want.span_draw);
            compare("intensity_out", got.intensity, want.intensity);
            compare("pad", got.pad, want.pad);
        end
        checked++;
    endtask
endclass

module polygon_scanline_span_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W      = ((2 * COORD_BITS_DEF + SCREEN_W + INTENS_W + 7) / 8) * 8;
    localparam int CYCLE_CAP = 4000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata = '0;   // vert_x, vert_y, scan_row, facet_intensity
    logic                  i_s_axis_tuser = 1'b0; // req_type
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;        // row_first, row_last, span_left,
                                                  // span_right, span_draw, intensity_out

    span_scoreboard board;
    bit             calm = 1'b0;
    int             accepted = 0;
    int             cycles = 0;

    polygon_scanline_span uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run-length guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_coord(int lim, bit wide);
        int v;
        if (wide)
            return $urandom_range(0, 8191) - 4096;
        v = $urandom_range(0, lim + 80) - 40;
        return (v > 4095) ? 4095 : v;
    endfunction

    function automatic int pick_intensity();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 6);
        return $urandom_range(0, 255);
    endfunction

    // result side: random stalls, check every accepted item
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                board.check_result(o_m_axis_tdata);
                hold = pick_gap();
            end else if (hold == 0 && $urandom_range(0, 15) == 0) begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // one request item, held until taken
    task automatic send_item(input logic kind, input int x, input int y, input logic last,
                             input int row, input int inten);
        logic [COORD_BITS_DEF-1:0] xs, ys;
        logic [SCREEN_W-1:0]       rows;
        logic [INTENS_W-1:0]       ints;
        int                        gap;
        xs   = x[COORD_BITS_DEF-1:0];
        ys   = y[COORD_BITS_DEF-1:0];
        rows = row[SCREEN_W-1:0];
        ints = inten[INTENS_W-1:0];
        gap  = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tlast  <= last;
        i_s_axis_tdata  <= {2'b00, ints, rows, ys, xs};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_request(kind, xs, ys, last, rows, ints);
        accepted++;
    endtask

    task automatic send_load(input int x, input int y, input logic last);
        send_item(REQ_LOAD, x, y, last, $urandom_range(0, 4095), $urandom_range(0, 255));
    endtask

    task automatic send_query(input int row, input int inten);
        send_item(REQ_QUERY, $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  $urandom_range(0, 1), row, inten);
    endtask

    // wait for an idle block, then rewrite all registers
    task automatic write_settings(input int mx, input int my, input logic refl);
        i_s_axis_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_MAX_X;
        i_cfg_wdata <= mx[CFG_DATA_W-1:0];
        board.set_register(CFG_MAX_X, mx[CFG_DATA_W-1:0]);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MAX_Y;
        i_cfg_wdata <= my[CFG_DATA_W-1:0];
        board.set_register(CFG_MAX_Y, my[CFG_DATA_W-1:0]);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_REFLECT;
        i_cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, refl};
        board.set_register(CFG_REFLECT, {{(CFG_DATA_W-1){1'b0}}, refl});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random facet, with occasional queries while open, then span queries mostly over its rows
    task automatic random_facet();
        int nv, nq, r, i, vx, vy, fmin, fmax, lo, hi, row;
        bit wide;
        r = $urandom_range(0, 99);
        if (r < 10)
            nv = $urandom_range(1, 2);
        else if (r < 88)
            nv = $urandom_range(3, 8);
        else
            nv = $urandom_range(14, 20);
        wide = ($urandom_range(0, 5) == 0);
        fmin = 4095;
        fmax = -4096;
        for (i = 0; i < nv; i++) begin
            vx = pick_coord(board.max_x, wide);
            vy = pick_coord(board.max_y, wide);
            if (vy < fmin) fmin = vy;
            if (vy > fmax) fmax = vy;
            send_load(vx, vy, i == nv - 1);
            // occasional query on a ring still open
            if (i < nv - 1 && $urandom_range(0, 9) == 0)
                send_query($urandom_range(0, board.max_y), pick_intensity());
        end
        lo = (fmin < 0) ? 0 : fmin;
        hi = fmax;
        nq = $urandom_range(1, 6);
        for (i = 0; i < nq; i++) begin
            if (lo > hi || $urandom_range(0, 4) == 0)
                row = $urandom_range(0, 4095);
            else
                row = $urandom_range(lo, hi);
            send_query(row, pick_intensity());
        end
    endtask

    // stimulus
    initial begin
        int ph, target;
        int set_x[5], set_y[5], set_r[5];
        int mx, my, refl;
        board = new;
        board.power_on();
        set_x = '{4095, 0, 4095, 0, 320};
        set_y = '{4095, 0, 0, 4095, 240};
        set_r = '{0, 1, 1, 0, 1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty store, a triangle, a full-range quad
        send_query(0, 9);
        send_load(100, 20, 1'b0);
        send_load(300, 200, 1'b0);
        send_load(50, 150, 1'b1);
        send_query(20, 255);
        send_query(100, 0);
        send_query(200, 7);
        send_query(4095, 128);
        send_load(-4096, -4096, 1'b0);
        send_load(4095, -4096, 1'b0);
        send_load(4095, 4095, 1'b0);
        send_load(-4096, 4095, 1'b1);
        send_query(0, 1);
        send_query(479, 200);

        // reflect dimming over its special values
        write_settings(639, 479, 1'b1);
        send_query(240, 0);
        send_query(240, 1);
        send_query(240, 2);
        send_query(240, 3);
        send_query(240, 4);
        send_query(240, 5);
        send_query(240, 6);
        send_query(240, 255);

        // random phases, extremes of the settings first
        for (ph = 0; ph < 8; ph++) begin
            if (ph < 5) begin
                mx   = set_x[ph];
                my   = set_y[ph];
                refl = set_r[ph];
            end else begin
                mx   = $urandom_range(0, 4095);
                my   = $urandom_range(0, 4095);
                refl = $urandom_range(0, 1);
            end
            write_settings(mx, my, refl[0]);
            calm   = (ph % 3 == 2);
            target = accepted + 225;
            while (accepted < target) begin
                if ($urandom_range(0, 99) < 85)
                    random_facet();
                else if ($urandom_range(0, 1) == 0)
                    send_load(pick_coord(board.max_x, 1'b1), pick_coord(board.max_y, 1'b1),
                              $urandom_range(0, 3) == 0);
                else
                    send_query($urandom_range(0, 4095), pick_intensity());
            end
        end

        // drain and let a late extra result show up
        i_s_axis_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
